FILE: design/psu_pkg.sv
// Shared types and constants of the PNG scanline unfilter.
package psu_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int WIDTH_CFG_W = 13;
    localparam int HEIGHT_W    = 16;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_HAS_ALPHA    = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    localparam logic [7:0] ALPHA_FILL = 8'hFF;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [1:0] channel_index;
        logic       row_end;
        logic       image_end;
        logic       filter_error;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [1:0]            index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    // one classified data byte, handed from the front to the back
    typedef struct packed {
        logic [7:0] raw;
        logic [2:0] filt;
        logic [1:0] ch;
        logic       first_row;
        logic       row_first;
        logic       err;
        logic       rend;
        logic       iend;
        logic       two;
    } t_ctl;

endpackage

FILE: design/psu_stream_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface psu_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter.
// A data byte passes the queue, the stage-one register and then the output register.
// Throughput: one input byte per cycle for RGBA while the output is ready; an RGB blue
// byte gives two results, blue then alpha, through the single output register.
// Filter-type bytes give no result and are not pushed into the queue.
// Reset is synchronous and clears control state; the line store is not cleared.
module png_scanline_unfilter #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psu_stream_if.sink   i_in,
    psu_stream_if.sink   i_cfg,
    psu_stream_if.source o_out
);

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_q_valid;
    psu_pkg::t_ctl w_f_ctl;
    logic [AW-1:0] w_f_addr;
    psu_pkg::t_ctl w_q_ctl;
    logic [AW-1:0] w_q_addr;

    psu_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_ctl   (w_f_ctl),
        .o_addr  (w_f_addr)
    );

    psu_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ctl   (w_f_ctl),
        .i_addr  (w_f_addr),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_ctl   (w_q_ctl),
        .o_addr  (w_q_addr)
    );

    psu_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_ctl   (w_q_ctl),
        .i_addr  (w_q_addr),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_split_is_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.last_of_run) |->
        (o_out.payload.channel_index == psu_pkg::CH_BLUE))
        else $error("non-final result on a channel other than blue");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.filter_error) |-> (o_out.payload.pixel_byte == 8'd0))
        else $error("pixel byte not zero under filter error");

endmodule

FILE: design/psu_front.sv
// Front end: configuration registers, row and column tracking, byte classification.
module psu_front #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int AW           = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    psu_stream_if.sink         i_in,
    psu_stream_if.sink         i_cfg,
    input  logic               i_full,
    output logic               o_push,
    output psu_pkg::t_ctl      o_ctl,
    output logic [AW-1:0]      o_addr
);

    localparam int DEPTH     = MAX_WIDTH * MAX_CHANNELS;
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int SW        = $clog2(4 * MAX_WIDTH + 1);
    localparam int EW        = (SW > psu_pkg::WIDTH_CFG_W) ? SW : psu_pkg::WIDTH_CFG_W;
    localparam int MOD3_LAST = (DEPTH - 1) % 3;
    localparam int MOD3_END  = DEPTH % 3;

    logic [psu_pkg::WIDTH_CFG_W-1:0] r_width;
    logic [psu_pkg::HEIGHT_W-1:0]    r_height;
    logic                            r_alpha;
    logic [CW-1:0]                   r_col;
    logic [1:0]                      r_mod3;
    logic [psu_pkg::HEIGHT_W-1:0]    r_row;
    logic [2:0]                      r_filt;
    logic                            r_await;
    logic                            r_err;
    logic                            r_row_first;

    logic                            w_acc;
    logic                            w_fs;
    logic [7:0]                      w_raw;
    logic                            w_await;
    logic                            w_err;
    logic [psu_pkg::HEIGHT_W-1:0]    w_row;
    logic                            w_bad_filt;
    logic                            w_clamp;
    logic [CW-1:0]                   w_col;
    logic [1:0]                      w_mod3;
    logic [1:0]                      w_ch;
    logic [CW-1:0]                   w_col_next;
    logic [EW-1:0]                   w_wext;
    logic [EW-1:0]                   w_wcl;
    logic [EW-1:0]                   w_stride;
    logic [psu_pkg::HEIGHT_W-1:0]    w_height;
    logic                            w_last_byte;
    logic                            w_last_row;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;

    assign w_acc   = i_in.valid && i_in.ready;
    assign w_fs    = i_in.payload.frame_start;
    assign w_raw   = i_in.payload.raw_byte;
    assign w_await = w_fs | r_await;
    assign w_err   = r_err & ~w_fs;
    assign w_row   = w_fs ? '0 : r_row;
    assign w_bad_filt = w_raw > 8'(psu_pkg::FILT_PAETH);

    // a frame start always lands on the filter branch, so data uses r_col, clamped below DEPTH
    assign w_clamp    = r_col >= CW'(DEPTH);
    assign w_col      = w_clamp ? CW'(DEPTH - 1) : r_col;
    assign w_mod3     = w_clamp ? 2'(MOD3_LAST) : r_mod3;
    assign w_ch       = r_alpha ? w_col[1:0] : w_mod3;
    assign w_col_next = w_col + CW'(1);

    assign w_wext = EW'(r_width);
    assign w_wcl  = (w_wext == '0) ? EW'(1) :
                    (w_wext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_wext;
    assign w_stride = r_alpha ? (w_wcl << 2) : (w_wcl + (w_wcl << 1));
    assign w_last_byte = EW'(w_col_next) >= w_stride;

    assign w_height   = (r_height == '0) ? psu_pkg::HEIGHT_W'(1) : r_height;
    assign w_last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, w_height};

    assign o_push = w_acc && !w_await;
    assign o_addr = w_col[AW-1:0];

    always_comb begin
        o_ctl           = '0;
        o_ctl.raw       = w_raw;
        o_ctl.filt      = r_filt;
        o_ctl.ch        = w_ch;
        o_ctl.first_row = (r_row == '0);
        o_ctl.row_first = r_row_first;
        o_ctl.err       = r_err;
        o_ctl.rend      = w_last_byte;
        o_ctl.iend      = w_last_byte && w_last_row;
        o_ctl.two       = !r_alpha && (w_ch == psu_pkg::CH_BLUE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= psu_pkg::WIDTH_CFG_W'(1);
            r_height    <= psu_pkg::HEIGHT_W'(1);
            r_alpha     <= 1'b1;
            r_col       <= '0;
            r_mod3      <= '0;
            r_row       <= '0;
            r_filt      <= psu_pkg::FILT_NONE;
            r_await     <= 1'b1;
            r_err       <= 1'b0;
            r_row_first <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.payload.index)
                    psu_pkg::CFG_IMAGE_WIDTH: begin
                        r_width <= i_cfg.payload.data[psu_pkg::WIDTH_CFG_W-1:0];
                    end
                    psu_pkg::CFG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg.payload.data[psu_pkg::HEIGHT_W-1:0];
                    end
                    psu_pkg::CFG_HAS_ALPHA: begin
                        r_alpha <= i_cfg.payload.data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (w_acc) begin
                if (w_await) begin
                    r_filt      <= w_bad_filt ? psu_pkg::FILT_NONE : w_raw[2:0];
                    r_err       <= w_err | w_bad_filt;
                    r_col       <= '0;
                    r_mod3      <= '0;
                    r_row       <= w_row;
                    r_await     <= 1'b0;
                    r_row_first <= 1'b1;
                end else begin
                    r_row_first <= 1'b0;
                    if (w_last_byte) begin
                        r_col   <= '0;
                        r_mod3  <= '0;
                        r_await <= 1'b1;
                        r_row   <= w_last_row ? '0 : r_row + psu_pkg::HEIGHT_W'(1);
                    end else begin
                        r_col  <= w_col_next;
                        r_mod3 <= w_clamp ? 2'(MOD3_END) :
                                  (w_mod3 == 2'd2) ? 2'd0 : w_mod3 + 2'd1;
                    end
                end
            end
        end
    end

endmodule

FILE: design/psu_queue.sv
// Two-entry queue between the front end and the reconstruction back end.
module psu_queue #(
    parameter int AW = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  psu_pkg::t_ctl  i_ctl,
    input  logic [AW-1:0]  i_addr,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output psu_pkg::t_ctl  o_ctl,
    output logic [AW-1:0]  o_addr
);

    psu_pkg::t_ctl r_ctl  [2];
    logic [AW-1:0] r_addr [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_ctl   = r_ctl[r_rp];
    assign o_addr  = r_addr[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wp]  <= i_ctl;
            r_addr[r_wp] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: design/psu_back.sv
// Back end: line store, predictor, reconstruction and output register.
module psu_back #(
    parameter int MAX_WIDTH    = 4096,
    parameter int MAX_CHANNELS = 4,
    parameter int AW           = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  psu_pkg::t_ctl  i_ctl,
    input  logic [AW-1:0]  i_addr,
    output logic           o_pop,
    psu_stream_if.source   o_out
);

    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;

    logic [7:0]    r_store [DEPTH];
    logic [7:0]    r_rd;
    psu_pkg::t_ctl r_s1;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_valid;
    logic          r_phase;
    logic [31:0]   r_left;
    logic [31:0]   r_upper;
    logic          r_out_valid;
    psu_pkg::t_out r_out;

    logic          w_out_load;
    logic          w_s1_done;
    logic          w_s1_load;
    logic [4:0]    w_sh;
    logic [31:0]   w_left_base;
    logic [31:0]   w_upper_base;
    logic [7:0]    w_a;
    logic [7:0]    w_b;
    logic [7:0]    w_c;
    logic signed [9:0] w_p;
    logic signed [9:0] w_pa;
    logic signed [9:0] w_pb;
    logic signed [9:0] w_pc;
    logic [7:0]    w_paeth;
    logic [7:0]    w_pred;
    logic [7:0]    w_recon;
    logic [31:0]   n_left;
    logic [31:0]   n_upper;
    psu_pkg::t_out n_out;

    assign w_out_load = r_s1_valid && (!r_out_valid || o_out.ready);
    assign w_s1_done  = w_out_load && (!r_s1.two || r_phase);
    assign w_s1_load  = i_valid && (!r_s1_valid || w_s1_done);
    assign o_pop      = w_s1_load;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // left and upper-left restart from zero on the first byte after a filter byte
    assign w_sh         = {r_s1.ch, 3'b000};
    assign w_left_base  = r_s1.row_first ? '0 : r_left;
    assign w_upper_base = (r_s1.row_first || r_s1.first_row) ? '0 : r_upper;
    assign w_a = w_left_base[w_sh +: 8];
    assign w_c = w_upper_base[w_sh +: 8];
    assign w_b = r_s1.first_row ? 8'd0 : r_rd;

    assign w_p  = $signed({2'b00, w_a}) + $signed({2'b00, w_b}) - $signed({2'b00, w_c});
    assign w_pa = (w_p > $signed({2'b00, w_a})) ? w_p - $signed({2'b00, w_a})
                                                : $signed({2'b00, w_a}) - w_p;
    assign w_pb = (w_p > $signed({2'b00, w_b})) ? w_p - $signed({2'b00, w_b})
                                                : $signed({2'b00, w_b}) - w_p;
    assign w_pc = (w_p > $signed({2'b00, w_c})) ? w_p - $signed({2'b00, w_c})
                                                : $signed({2'b00, w_c}) - w_p;

    always_comb begin
        if (w_pa <= w_pb && w_pa <= w_pc) begin
            w_paeth = w_a;
        end else if (w_pb <= w_pc) begin
            w_paeth = w_b;
        end else begin
            w_paeth = w_c;
        end
    end

    always_comb begin
        case (r_s1.filt)
            psu_pkg::FILT_SUB:   w_pred = w_a;
            psu_pkg::FILT_UP:    w_pred = w_b;
            psu_pkg::FILT_AVG:   w_pred = 8'((9'(w_a) + 9'(w_b)) >> 1);
            psu_pkg::FILT_PAETH: w_pred = w_paeth;
            default:             w_pred = 8'd0;
        endcase
    end

    assign w_recon = r_s1.err ? 8'd0 : r_s1.raw + w_pred;

    always_comb begin
        n_left  = w_left_base;
        n_upper = r_s1.row_first ? '0 : r_upper;
        n_left[w_sh +: 8]  = w_recon;
        n_upper[w_sh +: 8] = w_b;
    end

    always_comb begin
        n_out              = '0;
        n_out.filter_error = r_s1.err;
        if (r_phase) begin
            n_out.pixel_byte    = r_s1.err ? 8'd0 : psu_pkg::ALPHA_FILL;
            n_out.channel_index = psu_pkg::CH_ALPHA;
            n_out.row_end       = r_s1.rend;
            n_out.image_end     = r_s1.iend;
            n_out.last_of_run   = 1'b1;
        end else begin
            n_out.pixel_byte    = w_recon;
            n_out.channel_index = r_s1.ch;
            n_out.row_end       = !r_s1.two && (r_s1.ch == psu_pkg::CH_ALPHA) && r_s1.rend;
            n_out.image_end     = !r_s1.two && (r_s1.ch == psu_pkg::CH_ALPHA) && r_s1.iend;
            n_out.last_of_run   = !r_s1.two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_rd      <= r_store[i_addr];
            r_s1      <= i_ctl;
            r_s1_addr <= i_addr;
        end
        if (w_out_load && !r_phase) begin
            r_store[r_s1_addr] <= w_recon;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_upper     <= '0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_done) begin
                r_phase <= 1'b0;
            end else if (w_out_load) begin
                r_phase <= 1'b1;
            end
            if (w_out_load && !r_phase) begin
                r_left  <= n_left;
                r_upper <= n_upper;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
